FILE: rtl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
// No dependencies; used by hcbp_code_ram and huffman_code_bit_packer.
`default_nettype none

package hcbp_pkg;

    // Table geometry
    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 31;
    localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // Field widths
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 31;
    localparam int LEN_W   = 5;
    localparam int ACT_W   = 2;

    // Packer datapath
    localparam int BYTE_BITS = 8;
    localparam int FILL_W    = 3;                     // held bits 0..7
    localparam int WORK_W    = CODE_W + BYTE_BITS;    // held byte plus one code
    localparam int CNT_W     = 6;                     // up to 38 pending bits

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_END    = 2'd2
    } t_action;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_code_entry;

endpackage

`default_nettype wire

FILE: rtl/hcbp_code_ram.sv
// Code table storage: one write port, one registered read port.
// Depends on hcbp_pkg for the entry type and table depth.
`default_nettype none

module hcbp_code_ram (
    input  wire                          i_clk,
    input  wire                          i_wr_en,
    input  wire [hcbp_pkg::ADDR_W-1:0]   i_wr_addr,
    input  hcbp_pkg::t_code_entry        i_wr_data,
    input  wire                          i_rd_en,
    input  wire [hcbp_pkg::ADDR_W-1:0]   i_rd_addr,
    output hcbp_pkg::t_code_entry        o_rd_data
);

    hcbp_pkg::t_code_entry r_mem [hcbp_pkg::SYMBOL_COUNT];
    hcbp_pkg::t_code_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: sequencer, packing datapath, output register.
// Depends on hcbp_pkg and hcbp_code_ram.
`default_nettype none

// Channel     Direction  Handshake                    Payload
// ---------   ---------  ---------------------------  ------------------------------------------
// input       in         i_in_valid / o_in_ready      i_action, i_symbol, i_code_bits,
//                                                     i_code_length
// output      out        o_out_valid / i_out_ready    o_out_byte, o_last_byte
// config      in         i_cfg_wr_en (no wait)        i_cfg_wr_data (end symbol)
//
// A load transaction writes the code table in its accept cycle; ready stays high.
// An encode transaction runs the accept cycle with its table read, an align step, a merge
// step, an emit step that releases each full byte through the single 8-bit shift stage,
// and a step that holds back the partial byte. An end transaction needs no hold step
// and ends by releasing its final padded byte.
// A stalled output register holds the sequencer in its emit step; no byte is lost.
// Reset is synchronous, active low; the code table is not cleared and must be
// loaded before use.

module huffman_code_bit_packer (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input channel
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [hcbp_pkg::ACT_W-1:0]    i_action,
    input  wire [hcbp_pkg::SYM_W-1:0]    i_symbol,
    input  wire [hcbp_pkg::CODE_W-1:0]   i_code_bits,
    input  wire [hcbp_pkg::LEN_W-1:0]    i_code_length,
    // output channel
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [hcbp_pkg::BYTE_BITS-1:0] o_out_byte,
    output logic                         o_last_byte,
    // configuration
    input  wire                          i_cfg_wr_en,
    input  wire [hcbp_pkg::SYM_W-1:0]    i_cfg_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALIGN,
        S_MERGE,
        S_EMIT
    } t_state;

    t_state                              r_state;

    // packer state carried between transactions
    logic [hcbp_pkg::BYTE_BITS-1:0]      r_pack_byte;
    logic [hcbp_pkg::FILL_W-1:0]         r_bits_filled;
    logic [hcbp_pkg::SYM_W-1:0]          r_end_symbol;

    // per-transaction working registers
    logic                                r_is_end;
    logic                                r_sym_ok;
    logic [hcbp_pkg::CODE_W-1:0]         r_code_al;
    logic [hcbp_pkg::LEN_W-1:0]          r_len;
    logic [hcbp_pkg::WORK_W-1:0]         r_work;
    logic [hcbp_pkg::CNT_W-1:0]          r_cnt;

    // output register
    logic                                r_out_valid;
    logic [hcbp_pkg::BYTE_BITS-1:0]      r_out_byte;
    logic                                r_last_byte;

    // table port signals
    logic                                in_fire;
    logic                                tbl_wr_en;
    logic                                tbl_rd_en;
    logic [hcbp_pkg::SYM_W-1:0]          rd_sym;
    logic                                rd_sym_ok;
    logic                                wr_sym_ok;
    hcbp_pkg::t_code_entry               wr_entry;
    hcbp_pkg::t_code_entry               rd_entry;

    logic                                out_free;
    logic                                emit_now;
    logic [hcbp_pkg::WORK_W-1:0]         merged;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // A byte enters the output register this cycle: a full byte or the final one.
    assign emit_now = (r_state == S_EMIT) && out_free &&
                      ((r_cnt >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_BITS)) || r_is_end);

    // Symbols beyond the table load nothing and encode no bits.
    assign wr_sym_ok = ({1'b0, i_symbol} <
                        (hcbp_pkg::SYM_W+1)'(hcbp_pkg::SYMBOL_COUNT));
    assign rd_sym    = (i_action == hcbp_pkg::ACT_END) ? r_end_symbol : i_symbol;
    assign rd_sym_ok = ({1'b0, rd_sym} <
                        (hcbp_pkg::SYM_W+1)'(hcbp_pkg::SYMBOL_COUNT));

    assign tbl_wr_en = in_fire && (i_action == hcbp_pkg::ACT_LOAD) && wr_sym_ok;
    assign tbl_rd_en = in_fire && ((i_action == hcbp_pkg::ACT_ENCODE) ||
                                   (i_action == hcbp_pkg::ACT_END));

    // Saturate the length to the longest supported code.
    always_comb begin
        wr_entry.bits = i_code_bits;
        if (i_code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)) begin
            wr_entry.len = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN);
        end else begin
            wr_entry.len = i_code_length;
        end
    end

    hcbp_code_ram u_code_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (i_symbol[hcbp_pkg::ADDR_W-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (rd_sym[hcbp_pkg::ADDR_W-1:0]),
        .o_rd_data (rd_entry)
    );

    // Place the left-aligned code right behind the held bits. Held bits below the
    // fill point are zero unless a zero-length code was merged, so an OR merges the two.
    assign merged = {r_pack_byte, hcbp_pkg::CODE_W'(0)} |
                    ({r_code_al, hcbp_pkg::BYTE_BITS'(0)} >> r_bits_filled);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pack_byte   <= '0;
            r_bits_filled <= '0;
            r_end_symbol  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_end_symbol <= i_cfg_wr_data;
            end

            // raise valid for a new byte, drop the output transaction once taken
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (tbl_rd_en) begin
                        r_is_end <= (i_action == hcbp_pkg::ACT_END);
                        r_sym_ok <= rd_sym_ok;
                        r_state  <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    // Left-align the code; shifting out the top drops unused bits, but a zero length keeps bit 0.
                    if (r_sym_ok) begin
                        r_code_al <= rd_entry.bits <<
                                     (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - rd_entry.len);
                        r_len     <= rd_entry.len;
                    end else begin
                        r_code_al <= '0;
                        r_len     <= '0;
                    end
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    r_work  <= merged;
                    r_cnt   <= hcbp_pkg::CNT_W'(r_bits_filled) + hcbp_pkg::CNT_W'(r_len);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_cnt >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_BITS)) begin
                        // release one full byte, advance by one byte
                        if (out_free) begin
                            r_out_byte  <= r_work[hcbp_pkg::WORK_W-1 -: hcbp_pkg::BYTE_BITS];
                            r_last_byte <= 1'b0;
                            r_work      <= r_work << hcbp_pkg::BYTE_BITS;
                            r_cnt       <= r_cnt - hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_BITS);
                        end
                    end else if (r_is_end) begin
                        // final padded byte, then clear the packer
                        if (out_free) begin
                            r_out_byte    <= r_work[hcbp_pkg::WORK_W-1 -: hcbp_pkg::BYTE_BITS];
                            r_last_byte   <= 1'b1;
                            r_pack_byte   <= '0;
                            r_bits_filled <= '0;
                            r_state       <= S_IDLE;
                        end
                    end else begin
                        // hold the partial byte for the next transaction
                        r_pack_byte   <= r_work[hcbp_pkg::WORK_W-1 -: hcbp_pkg::BYTE_BITS];
                        r_bits_filled <= r_cnt[hcbp_pkg::FILL_W-1:0];
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_last_byte;

endmodule

`default_nettype wire
